[rtl/ffrb_pkg.sv]
// Shared constants, command and status codes for the feature frame ring buffer.
package ffrb_pkg;

    localparam int FRAMES_MAX  = 32;
    localparam int MAX_DIM     = 64;
    localparam int WORD_BITS   = 32;
    localparam int STORE_DEPTH = FRAMES_MAX * MAX_DIM;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int ELEM_BITS   = $clog2(MAX_DIM);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_PUSH  = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_DATA     = 3'd0;
    localparam status_t ST_FILL     = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_CAPACITY = 3'd3;
    localparam status_t ST_RANGE    = 3'd4;

    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_DIM    = 1'b1;

endpackage

[rtl/ffrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/feature_frame_ring_buffer_unit.sv]
// Top level of the feature frame ring buffer: pointer control, checks and store.
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+--------------------
//  command   | cmd, push_word, read_frame, read_element,          | start && !busy
//            | capacity_words                                     |
//  result    | word_out, read_status                              | done, one cycle
//  config    | cfg_index, cfg_wdata                               | cfg_we
//
// One beat is taken every cycle; busy is never raised.
// A read command gives its result in the cycle after acceptance (registered store read);
// push, clear and unused commands give no result.
// Reset clears pointers and restores the window size; store contents are not cleared.
// The receiver cannot stall, so there is no back pressure on the result side.
module feature_frame_ring_buffer_unit
    import ffrb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             cmd,
    input  logic [WORD_BITS-1:0]   push_word,
    input  logic [4:0]             read_frame,
    input  logic [5:0]             read_element,
    input  logic [11:0]            capacity_words,
    output logic                   done,
    output logic [WORD_BITS-1:0]   word_out,
    output logic [2:0]             read_status,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [6:0]             cfg_wdata
);

    logic [5:0]  frames_reg, frames_next;
    logic [6:0]  dim_reg, dim_next;
    logic [4:0]  head_reg, head_next;
    logic [5:0]  elem_reg, elem_next;
    logic        full_reg, full_next;
    logic        done_reg, done_next;
    status_t     status_reg, status_next;

    logic        accept;
    logic        do_push;
    logic        do_read;
    logic [5:0]  frames_held;
    logic [12:0] required;
    logic [12:0] total;
    logic [5:0]  pos_sum;
    logic [5:0]  pos;
    logic [6:0]  elem_inc;
    logic [5:0]  head_inc;
    logic [ADDR_BITS-1:0] waddr;
    logic [ADDR_BITS-1:0] raddr;
    logic [WORD_BITS-1:0] rdata;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign do_push = accept && (cmd == CMD_PUSH);
    assign do_read = accept && (cmd == CMD_READ);

    assign frames_held = full_reg ? frames_reg : {1'b0, head_reg};
    assign required    = {7'd0, frames_held} * {6'd0, dim_reg};
    assign total       = {7'd0, frames_reg} * {6'd0, dim_reg};

    // oldest frame sits at the head once the window has wrapped
    assign pos_sum = (full_reg ? {1'b0, head_reg} : 6'd0) + {1'b0, read_frame};
    assign pos     = (pos_sum >= frames_reg) ? 6'(pos_sum - frames_reg) : pos_sum;
    assign raddr   = {pos[4:0], read_element};
    assign waddr   = {head_reg, elem_reg};

    assign elem_inc = {1'b0, elem_reg} + 7'd1;
    assign head_inc = {1'b0, head_reg} + 6'd1;

    always_comb
    begin
        frames_next = frames_reg;
        dim_next    = dim_reg;
        head_next   = head_reg;
        elem_next   = elem_reg;
        full_next   = full_reg;
        done_next   = do_read;
        status_next = status_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAMES:
                begin
                    if (cfg_wdata[5:0] == 6'd0)
                        frames_next = 6'd1;
                    else if (cfg_wdata[5:0] > 6'(FRAMES_MAX))
                        frames_next = 6'(FRAMES_MAX);
                    else
                        frames_next = cfg_wdata[5:0];
                end
                REG_DIM:
                begin
                    if (cfg_wdata == 7'd0)
                        dim_next = 7'd1;
                    else if (cfg_wdata > 7'(MAX_DIM))
                        dim_next = 7'(MAX_DIM);
                    else
                        dim_next = cfg_wdata;
                end
                default: ;
            endcase
            head_next = '0;
            elem_next = '0;
            full_next = 1'b0;
        end
        else if (accept)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (elem_inc >= dim_reg)
                    begin
                        elem_next = '0;
                        if (head_inc >= frames_reg)
                        begin
                            head_next = '0;
                            full_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_inc[4:0];
                        end
                    end
                    else
                    begin
                        elem_next = elem_inc[5:0];
                    end
                end
                CMD_CLEAR:
                begin
                    head_next = '0;
                    elem_next = '0;
                    full_next = 1'b0;
                end
                CMD_READ:
                begin
                    if (frames_held == 6'd0)
                        status_next = ST_EMPTY;
                    else if ({1'b0, capacity_words} < required)
                        status_next = ST_CAPACITY;
                    else if ({1'b0, read_element} >= dim_reg
                             || {1'b0, read_frame} >= frames_reg)
                        status_next = ST_RANGE;
                    else if ({1'b0, read_frame} < frames_held)
                        status_next = ST_DATA;
                    else if ({1'b0, capacity_words} >= total)
                        status_next = ST_FILL;
                    else
                        status_next = ST_CAPACITY;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= 6'(FRAMES_MAX);
            dim_reg    <= 7'd39;
            head_reg   <= '0;
            elem_reg   <= '0;
            full_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            frames_reg <= frames_next;
            dim_reg    <= dim_next;
            head_reg   <= head_next;
            elem_reg   <= elem_next;
            full_reg   <= full_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    ffrb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_push),
        .waddr (waddr),
        .wdata (push_word),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign done        = done_reg;
    assign read_status = status_reg;
    assign word_out    = (status_reg == ST_DATA) ? rdata : '0;

endmodule
